// ----- rtl/harmonic_spring_energy_gradient_assert.svh -----
// Assertion macros shared by the harmonic spring energy and gradient RTL.
// Each macro expands to one labeled concurrent assertion on i_clk with reset disable.
`ifndef HARMONIC_SPRING_ENERGY_GRADIENT_ASSERT_SVH
`define HARMONIC_SPRING_ENERGY_GRADIENT_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define HSEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Implication that checks its consequent in the cycle after the antecedent.
`define HSEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/hseg_pkg.sv -----
// Package for the harmonic spring energy and gradient block.
// Holds widths, the queue entry type and the back-end state type. No dependencies.
package hseg_pkg;
    localparam int ATOM_INDEX_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int COORD_W  = 28;
    localparam int SEP_W    = 29;
    localparam int REST_W   = 27;
    localparam int K_W      = 32;
    localparam int OUT_W    = 48;
    localparam int D2_W     = 58;
    localparam int DIST_W   = 29;
    localparam int QUEUE_DEPTH = 2;

    // Work item passed from the front end to the back end.
    typedef struct packed {
        logic [ATOM_INDEX_BITS_DEF-1:0] atom_a;
        logic [ATOM_INDEX_BITS_DEF-1:0] atom_b;
        logic signed [SEP_W-1:0]        sx;
        logic signed [SEP_W-1:0]        sy;
        logic signed [SEP_W-1:0]        sz;
        logic [REST_W-1:0]              rest;
        logic [K_W-1:0]                 k;
        logic                           last;
    } t_item;

    // Result carried to the output queue.
    typedef struct packed {
        logic [ATOM_INDEX_BITS_DEF-1:0] atom_a;
        logic [ATOM_INDEX_BITS_DEF-1:0] atom_b;
        logic [OUT_W-1:0]               gx;
        logic [OUT_W-1:0]               gy;
        logic [OUT_W-1:0]               gz;
        logic [OUT_W-1:0]               term;
        logic [OUT_W-1:0]               total;
        logic                           zero;
        logic                           last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_SQRT, ST_DIFF, ST_EMUL, ST_KD, ST_ESUM,
        ST_GMUL, ST_GDIV, ST_GSAT, ST_DONE
    } t_state;
endpackage

// ----- rtl/harmonic_spring_energy_gradient.sv -----
// Harmonic spring energy and gradient, one spring per transfer.
// The result reaches the ports after a 29-step square root, then three 96-step restoring
// divisions; at zero distance the divisions are skipped.
// The back end takes a new spring only once its last result has left; the shared divider limits the rate.
// A two-entry queue feeds the back end; results wait in a one-entry output register.
// Reset (synchronous, active low) empties the queues and clears the energy total.
module harmonic_spring_energy_gradient #(
    parameter int ATOM_INDEX_BITS = hseg_pkg::ATOM_INDEX_BITS_DEF,
    parameter int FRACTION_BITS   = hseg_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [15:0]          i_first_atom,
    input  logic [15:0]          i_second_atom,
    input  logic signed [27:0]   i_first_x,
    input  logic signed [27:0]   i_first_y,
    input  logic signed [27:0]   i_first_z,
    input  logic signed [27:0]   i_second_x,
    input  logic signed [27:0]   i_second_y,
    input  logic signed [27:0]   i_second_z,
    input  logic [26:0]          i_rest_length,
    input  logic [31:0]          i_stiffness,
    input  logic                 i_last,
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          o_atom_a,
    output logic [15:0]          o_atom_b,
    output logic signed [47:0]   o_grad_x,
    output logic signed [47:0]   o_grad_y,
    output logic signed [47:0]   o_grad_z,
    output logic [47:0]          o_energy_term,
    output logic [47:0]          o_energy_total,
    output logic                 o_zero_distance,
    output logic                 o_last_out
);
    import hseg_pkg::*;

    logic      w_item_valid, w_item_take, w_res_valid, w_res_ready;
    t_item     w_item;
    t_result   w_res;
    t_result   r_out;
    logic      r_full;

    hseg_front #(.ATOM_INDEX_BITS(ATOM_INDEX_BITS)) u_front (
        .i_clk, .i_rst_n, .push, .full,
        .i_first_atom, .i_second_atom,
        .i_first_x, .i_first_y, .i_first_z,
        .i_second_x, .i_second_y, .i_second_z,
        .i_rest_length, .i_stiffness, .i_last,
        .o_item_valid(w_item_valid), .o_item(w_item), .i_item_take(w_item_take)
    );

    hseg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_item_valid(w_item_valid), .i_item(w_item), .o_item_take(w_item_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_ready(w_res_ready)
    );

    // Output register: loads when free or being popped.
    assign w_res_ready = !r_full || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (w_res_ready) begin
            r_full <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign empty           = !r_full;
    assign o_atom_a        = r_out.atom_a;
    assign o_atom_b        = r_out.atom_b;
    assign o_grad_x        = r_out.gx;
    assign o_grad_y        = r_out.gy;
    assign o_grad_z        = r_out.gz;
    assign o_energy_term   = r_out.term;
    assign o_energy_total  = r_out.total;
    assign o_zero_distance = r_out.zero;
    assign o_last_out      = r_out.last;
endmodule

// ----- rtl/hseg_front.sv -----
// Front end: accepts springs, forms the separation vector, queues work items.
// Depends on hseg_pkg.
module hseg_front #(
    parameter int ATOM_INDEX_BITS = hseg_pkg::ATOM_INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [15:0]                   i_first_atom,
    input  logic [15:0]                   i_second_atom,
    input  logic signed [27:0]            i_first_x,
    input  logic signed [27:0]            i_first_y,
    input  logic signed [27:0]            i_first_z,
    input  logic signed [27:0]            i_second_x,
    input  logic signed [27:0]            i_second_y,
    input  logic signed [27:0]            i_second_z,
    input  logic [26:0]                   i_rest_length,
    input  logic [31:0]                   i_stiffness,
    input  logic                          i_last,
    output logic                          o_item_valid,
    output hseg_pkg::t_item               o_item,
    input  logic                          i_item_take
);
    import hseg_pkg::*;

    t_item          r_q [QUEUE_DEPTH];
    logic           r_wp, n_wp, r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    t_item          w_new;
    logic           w_push;
    logic [15:0]    w_mask;

    assign w_mask = 16'((32'd1 << ATOM_INDEX_BITS) - 32'd1);

    // Classify the incoming spring into a work item.
    always_comb begin
        w_new.atom_a = i_first_atom & w_mask;
        w_new.atom_b = i_second_atom & w_mask;
        w_new.sx     = SEP_W'(i_second_x) - SEP_W'(i_first_x);
        w_new.sy     = SEP_W'(i_second_y) - SEP_W'(i_first_y);
        w_new.sz     = SEP_W'(i_second_z) - SEP_W'(i_first_z);
        w_new.rest   = i_rest_length;
        w_new.k      = i_stiffness;
        w_new.last   = i_last;
    end

    assign full         = (r_cnt == 2'(QUEUE_DEPTH));
    assign w_push       = push && !full;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // Queue pointers.
    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_item_take;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_item_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

`include "harmonic_spring_energy_gradient_assert.svh"
    `HSEG_ASSERT(a_front_cnt, r_cnt <= 2'(QUEUE_DEPTH), "front queue overfilled")
    `HSEG_ASSERT(a_front_take, !i_item_take || o_item_valid, "take from empty queue")
    `HSEG_ASSERT_NEXT(a_front_fill, w_push && !i_item_take, r_cnt == $past(r_cnt) + 2'd1,
        "push lost")
endmodule

// ----- rtl/hseg_back.sv -----
// Back end: distance by iterative square root, energy, gradient by iterative division.
// Depends on hseg_pkg; hands results to the output queue in the top level.
module hseg_back #(
    parameter int FRACTION_BITS = hseg_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  hseg_pkg::t_item      i_item,
    output logic                 o_item_take,
    output logic                 o_res_valid,
    output hseg_pkg::t_result    o_res,
    input  logic                 i_res_ready
);
    import hseg_pkg::*;

    localparam int SQ_STEPS = D2_W / 2;
    localparam int NUM_W    = 96;

    t_state            r_st, n_st;
    t_item             r_it;
    logic [1:0]        r_idx;
    logic [D2_W-1:0]   r_sq [3];
    logic [D2_W-1:0]   r_rem;
    logic [DIST_W-1:0] r_root;
    logic [6:0]        r_cnt;
    logic [DIST_W-1:0] r_dist;
    logic              r_dneg;
    logic [DIST_W-1:0] r_dmag;
    logic [63:0]       r_dsq;
    logic [63:0]       r_kd;
    logic [OUT_W-1:0]  r_term;
    logic [OUT_W-1:0]  r_acc;
    logic [OUT_W-1:0]  r_g [3];
    logic [NUM_W-1:0]  r_num;
    logic [63:0]       r_drem;
    logic [NUM_W-1:0]  r_quo;
    logic [63:0]       r_den;
    logic [95:0]       r_pp;

    logic [SEP_W-1:0]  w_abs [3];
    logic [SEP_W-1:0]  w_cur_abs;
    logic              w_cur_neg;
    logic [D2_W+1:0]   w_trial;
    logic [D2_W-1:0]   w_rem2;
    logic [64:0]       w_dr;
    logic              w_ge;
    logic [OUT_W:0]    w_tot;

    function automatic logic [OUT_W-1:0] energy_sat(input logic [95:0] lo,
                                                     input logic [63:0] hi);
        logic [127:0] p;
        logic [127:0] s;
        begin
            p = 128'(lo) + (128'(hi) << 32);
            s = p >> (2 * FRACTION_BITS + 1);
            energy_sat = (s[127:OUT_W] != '0) ? {OUT_W{1'b1}} : s[OUT_W-1:0];
        end
    endfunction

    // Absolute separation components.
    always_comb begin
        w_abs[0] = r_it.sx[SEP_W-1] ? SEP_W'(-r_it.sx) : SEP_W'(r_it.sx);
        w_abs[1] = r_it.sy[SEP_W-1] ? SEP_W'(-r_it.sy) : SEP_W'(r_it.sy);
        w_abs[2] = r_it.sz[SEP_W-1] ? SEP_W'(-r_it.sz) : SEP_W'(r_it.sz);
        w_cur_abs = w_abs[r_idx];
        case (r_idx)
            2'd0:    w_cur_neg = r_it.sx[SEP_W-1];
            2'd1:    w_cur_neg = r_it.sy[SEP_W-1];
            default: w_cur_neg = r_it.sz[SEP_W-1];
        endcase
    end

    // One square root digit per cycle: two radicand bits in, one root bit out.
    always_comb begin
        w_rem2  = {r_rem[D2_W-3:0], 2'b00};
        w_trial = {r_rem, r_sq[0][D2_W-1 -: 2]} - {1'b0, r_root[DIST_W-2:0], 2'b01};
    end

    // One quotient bit per cycle of the restoring division.
    always_comb begin
        w_dr = {r_drem, r_num[NUM_W-1]};
        w_ge = (w_dr >= {1'b0, r_den});
    end

    assign w_tot = {1'b0, r_acc} + {1'b0, r_term};

    // Next-state logic.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_item_valid) n_st = ST_SQ;
            ST_SQ:   if (r_idx == 2'd2) n_st = ST_SUM;
            ST_SUM:  n_st = ST_SQRT;
            ST_SQRT: if (r_cnt == 7'(SQ_STEPS - 1)) n_st = ST_DIFF;
            ST_DIFF: n_st = ST_EMUL;
            ST_EMUL: n_st = ST_KD;
            ST_KD:   n_st = ST_ESUM;
            ST_ESUM: n_st = (r_dist == '0) ? ST_DONE : ST_GMUL;
            ST_GMUL: n_st = ST_GDIV;
            ST_GDIV: if (r_cnt == 7'(NUM_W - 1)) n_st = ST_GSAT;
            ST_GSAT: n_st = (r_idx == 2'd2) ? ST_DONE : ST_GMUL;
            ST_DONE: if (i_res_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        o_item_take = (r_st == ST_IDLE) && i_item_valid;
        o_res_valid = (r_st == ST_DONE);
        o_res.atom_a = r_it.atom_a;
        o_res.atom_b = r_it.atom_b;
        o_res.gx     = r_g[0];
        o_res.gy     = r_g[1];
        o_res.gz     = r_g[2];
        o_res.term   = r_term;
        o_res.total  = w_tot[OUT_W] ? {OUT_W{1'b1}} : w_tot[OUT_W-1:0];
        o_res.zero   = (r_dist == '0);
        o_res.last   = r_it.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_acc <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_DONE && i_res_ready) begin
                r_acc <= r_it.last ? '0 : o_res.total;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_it  <= i_item;
                r_idx <= 2'd0;
            end
            ST_SQ: begin
                r_sq[r_idx] <= D2_W'(w_cur_abs) * D2_W'(w_cur_abs);
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            ST_SUM: begin
                r_sq[0] <= r_sq[0] + r_sq[1] + r_sq[2];
                r_rem   <= '0;
                r_root  <= '0;
                r_cnt   <= '0;
            end
            ST_SQRT: begin
                if (!w_trial[D2_W+1]) begin
                    r_rem  <= D2_W'(w_trial);
                    r_root <= {r_root[DIST_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2 | D2_W'(r_sq[0][D2_W-1 -: 2]);
                    r_root <= {r_root[DIST_W-2:0], 1'b0};
                end
                r_sq[0] <= {r_sq[0][D2_W-3:0], 2'b00};
                r_cnt   <= r_cnt + 7'd1;
            end
            ST_DIFF: begin
                r_dist <= r_root;
                r_dneg <= (r_root < DIST_W'(r_it.rest));
                r_dmag <= (r_root < DIST_W'(r_it.rest)) ? DIST_W'(r_it.rest) - r_root
                                                        : r_root - DIST_W'(r_it.rest);
            end
            ST_EMUL: begin
                r_dsq <= 64'(r_dmag) * 64'(r_dmag);
                r_kd  <= 64'(r_it.k) * 64'(r_dmag);
            end
            ST_KD: begin
                // Energy: k * dmag^2 >> (2F+1), the product taken in halves.
                r_pp   <= 96'(r_it.k) * 96'(r_dsq[31:0]);
                r_term <= '0;
                r_g[0] <= '0;
                r_g[1] <= '0;
                r_g[2] <= '0;
                r_idx  <= 2'd0;
                r_den  <= 64'(r_dist) << FRACTION_BITS;
            end
            ST_ESUM: begin
                // High partial product combined with the low one.
                r_term <= energy_sat(r_pp, 64'(r_it.k) * 64'(r_dsq[63:32]));
            end
            ST_GMUL: begin
                // Numerator k * dmag * |s|, formed from two partial products.
                r_num  <= NUM_W'(64'(r_kd[31:0]) * 64'(w_cur_abs)) +
                          (NUM_W'(64'(r_kd[63:32]) * 64'(w_cur_abs)) << 32);
                r_drem <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            ST_GDIV: begin
                r_drem <= w_ge ? 64'(w_dr - {1'b0, r_den}) : w_dr[63:0];
                r_quo  <= {r_quo[NUM_W-2:0], w_ge};
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 7'd1;
            end
            ST_GSAT: begin
                if (r_quo == '0) begin
                    r_g[r_idx] <= '0;
                end else if (r_dneg == w_cur_neg) begin
                    r_g[r_idx] <= (r_quo >= NUM_W'(1) << 47) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                           : OUT_W'(-r_quo);
                end else begin
                    r_g[r_idx] <= (r_quo > (NUM_W'(1) << 47) - 1) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                               : OUT_W'(r_quo);
                end
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            default: ;
        endcase
    end

`include "harmonic_spring_energy_gradient_assert.svh"
    `HSEG_ASSERT(a_back_take, !o_item_take || r_st == ST_IDLE, "item taken while busy")
    `HSEG_ASSERT_NEXT(a_back_hold, o_res_valid && !i_res_ready, o_res_valid,
        "result dropped before transfer")
    `HSEG_ASSERT(a_back_zero, !(o_res_valid && o_res.zero) ||
        (r_g[0] == '0 && r_g[1] == '0 && r_g[2] == '0), "gradient at zero distance")
endmodule
